// File: rtl/mlfs_pkg.sv
package mlfs_pkg;

    localparam int LEVELS    = 3;
    localparam int LEVEL_W   = 2;
    localparam int ID_W      = 4;
    localparam int BURST_W   = 8;
    localparam int SLICE_W   = 8;
    localparam int CFG_IDX_W = 2;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int PROC_COUNT_DEF  = 16;

    typedef logic [ID_W-1:0]    t_id;
    typedef logic [LEVEL_W-1:0] t_level;
    typedef logic [BURST_W-1:0] t_burst;
    typedef logic [SLICE_W-1:0] t_slice;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    typedef enum logic {
        ACT_ARRIVAL = 1'b0,
        ACT_TICK    = 1'b1
    } t_action;

    localparam t_cfg_idx CFG_SLICE_TOP = 2'd0;
    localparam t_cfg_idx CFG_SLICE_MID = 2'd1;
    localparam t_cfg_idx CFG_SLICE_LOW = 2'd2;

    localparam t_level LVL_TOP = 2'd0;
    localparam t_level LVL_MID = 2'd1;
    localparam t_level LVL_LOW = 2'd2;

    localparam t_slice SLICE_RST [LEVELS] = '{8'd1, 8'd2, 8'd4};

    typedef struct packed {
        t_action action;
        t_id     proc_id;
        t_burst  burst;
    } t_in_item;

    typedef struct packed {
        logic   run_valid;
        t_id    run_id;
        t_level run_level;
        logic   finished;
        logic   dropped;
    } t_out_item;

    typedef struct packed {
        logic push;
        logic pop;
        t_id  push_id;
    } t_fifo_ctrl;

    typedef struct packed {
        logic empty;
        logic full;
        t_id  head;
    } t_fifo_stat;

endpackage

// File: rtl/mlfs_if.sv
interface mlfs_in_if import mlfs_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   action;
    t_id    proc_id;
    t_burst burst;

    modport source (output valid, action, proc_id, burst, input ready);
    modport sink   (input valid, action, proc_id, burst, output ready);
endinterface

interface mlfs_out_if import mlfs_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   run_valid;
    t_id    run_id;
    t_level run_level;
    logic   finished;
    logic   dropped;

    modport source (output valid, run_valid, run_id, run_level, finished, dropped,
                    input ready);
    modport sink   (input valid, run_valid, run_id, run_level, finished, dropped,
                    output ready);
endinterface

interface mlfs_cfg_if import mlfs_pkg::*; ();
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_slice   wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink   (input valid, index, wdata, output ready);
endinterface

// File: rtl/mlfs_level_fifo.sv
module mlfs_level_fifo import mlfs_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_fifo_ctrl i_ctrl,
    output t_fifo_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [PTR_W-1:0] r_head, r_tail;
    logic [CNT_W-1:0] r_count;
    t_id              r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_ctrl.push) begin
                r_tail <= (r_tail == LAST) ? '0 : r_tail + 1'b1;
            end
            if (i_ctrl.pop) begin
                r_head <= (r_head == LAST) ? '0 : r_head + 1'b1;
            end
            case ({i_ctrl.push, i_ctrl.pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_tail] <= i_ctrl.push_id;
        end
    end

    // empty queue: a beat pushed this cycle is visible at the head
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.head  = o_stat.empty ? i_ctrl.push_id : r_mem[r_head];

endmodule

// File: rtl/mlfs_engine.sv
module mlfs_engine import mlfs_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int PROC_COUNT  = PROC_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  t_in_item                       i_item,
    input  logic [LEVELS-1:0][SLICE_W-1:0] i_slices,
    output t_out_item                      o_result
);

    localparam int PIDX_W = $clog2(PROC_COUNT);

    t_fifo_ctrl ctrl [LEVELS];
    t_fifo_stat stat [LEVELS];

    t_burst r_remain [PROC_COUNT];
    logic   r_hold_valid, n_hold_valid;
    t_id    r_hold_id, n_hold_id;
    t_level r_hold_level, n_hold_level;
    t_slice r_slice_used, n_slice_used;
    logic   r_pend_valid, n_pend_valid;
    t_id    r_pend_id, n_pend_id;
    t_level r_pend_level, n_pend_level;

    logic              rem_we;
    logic [PIDX_W-1:0] rem_idx;
    t_burst            rem_wdata;

    for (genvar g = 0; g < LEVELS; g++) begin : g_lvl
        mlfs_level_fifo #(
            .DEPTH (QUEUE_DEPTH)
        ) u_fifo (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl[g]),
            .o_stat  (stat[g])
        );
    end

    always_comb begin
        logic              all_empty;
        logic              found;
        logic [LEVELS-1:0] avail;
        t_level            rq_lvl;
        logic              cur_valid;
        t_id               cur_id;
        t_level            cur_lvl;
        t_slice            cur_su;
        t_slice            su_inc;
        t_slice            sl;
        t_burst            rem;
        t_burst            rem_dec;

        for (int k = 0; k < LEVELS; k++) begin
            ctrl[k] = '0;
        end
        o_result     = '0;
        rem_we       = 1'b0;
        rem_idx      = PIDX_W'(i_item.proc_id);
        rem_wdata    = '0;
        n_hold_valid = r_hold_valid;
        n_hold_id    = r_hold_id;
        n_hold_level = r_hold_level;
        n_slice_used = r_slice_used;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        n_pend_level = r_pend_level;
        all_empty    = stat[0].empty && stat[1].empty && stat[2].empty;
        found        = 1'b0;
        avail        = '0;
        rq_lvl       = LVL_TOP;
        cur_valid    = r_hold_valid;
        cur_id       = r_hold_id;
        cur_lvl      = r_hold_level;
        cur_su       = r_slice_used;
        su_inc       = '0;
        sl           = '0;
        rem          = '0;
        rem_dec      = '0;

        if (i_step) begin
            if (i_item.action == ACT_ARRIVAL) begin
                if (int'(i_item.proc_id) >= PROC_COUNT || stat[0].full) begin
                    o_result.dropped = 1'b1;
                end else begin
                    ctrl[0].push    = 1'b1;
                    ctrl[0].push_id = i_item.proc_id;
                    rem_we          = 1'b1;
                    rem_wdata       = (i_item.burst == '0) ? t_burst'(1) : i_item.burst;
                end
            end else begin
                if (r_pend_valid) begin
                    if (all_empty) begin
                        rq_lvl = LVL_TOP;
                    end else begin
                        rq_lvl = (r_pend_level == LVL_TOP) ? LVL_MID : LVL_LOW;
                    end
                    if (stat[rq_lvl].full) begin
                        o_result.dropped = 1'b1;
                    end else begin
                        ctrl[rq_lvl].push    = 1'b1;
                        ctrl[rq_lvl].push_id = r_pend_id;
                    end
                    n_pend_valid = 1'b0;
                end

                for (int k = 0; k < LEVELS; k++) begin
                    avail[k] = !stat[k].empty || ctrl[k].push;
                end

                if (!r_hold_valid) begin
                    for (int k = 0; k < LEVELS; k++) begin
                        if (!found && avail[k]) begin
                            found       = 1'b1;
                            ctrl[k].pop = 1'b1;
                            cur_id      = stat[k].head;
                            cur_lvl     = t_level'(k);
                        end
                    end
                    cur_valid = found;
                    cur_su    = '0;
                end

                if (cur_valid) begin
                    rem_idx   = PIDX_W'(cur_id);
                    rem       = r_remain[rem_idx];
                    rem_dec   = (rem != '0) ? rem - 1'b1 : rem;
                    su_inc    = (cur_su != '1) ? cur_su + 1'b1 : cur_su;
                    sl        = i_slices[cur_lvl];
                    sl        = (sl == '0) ? t_slice'(1) : sl;
                    rem_we    = 1'b1;
                    rem_wdata = rem_dec;

                    o_result.run_valid = 1'b1;
                    o_result.run_id    = cur_id;
                    o_result.run_level = cur_lvl;

                    n_hold_id    = cur_id;
                    n_hold_level = cur_lvl;
                    n_slice_used = su_inc;
                    if (rem_dec == '0) begin
                        o_result.finished = 1'b1;
                        n_hold_valid      = 1'b0;
                    end else if (su_inc >= sl) begin
                        n_hold_valid = 1'b0;
                        n_pend_valid = 1'b1;
                        n_pend_id    = cur_id;
                        n_pend_level = cur_lvl;
                    end else begin
                        n_hold_valid = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_hold_id    <= '0;
            r_hold_level <= '0;
            r_slice_used <= '0;
            r_pend_valid <= 1'b0;
            r_pend_id    <= '0;
            r_pend_level <= '0;
        end else begin
            r_hold_valid <= n_hold_valid;
            r_hold_id    <= n_hold_id;
            r_hold_level <= n_hold_level;
            r_slice_used <= n_slice_used;
            r_pend_valid <= n_pend_valid;
            r_pend_id    <= n_pend_id;
            r_pend_level <= n_pend_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rem_we) begin
            r_remain[rem_idx] <= rem_wdata;
        end
    end

endmodule

// File: rtl/multilevel_feedback_scheduler.sv
// Three-level feedback scheduler.
// i_sched_in  : one beat per event, action 0 = arrival (proc_id, burst), 1 = tick.
// o_sched_out : exactly one beat per input beat, in order: the process run on a
//               tick with its level and finish flag, plus the drop flag.
// i_cfg       : writes the slice length of level 0..2 (index 0..2); other indexes
//               are ignored. Write only when no beat is in flight.
// Path: a taken input beat goes to the input register, then its result to the
// result register. Throughput: one beat per cycle unless the receiver stalls; the
// whole update for one event (requeue, pick from the three queues, unit of
// service) sits between those two registers.
// A stalled receiver holds the result register; the input register still takes
// one more beat, after which ready drops until the result is taken.
// Reset clears the queue pointers, holder and pending state and loads the slices
// with 1, 2 and 4; ready is low while reset is held. Queue entries and service
// counts are not cleared and are only read after being written.
module multilevel_feedback_scheduler import mlfs_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int PROC_COUNT  = PROC_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mlfs_in_if.sink     i_sched_in,
    mlfs_out_if.source  o_sched_out,
    mlfs_cfg_if.sink    i_cfg
);

    logic                           r_in_valid;
    t_in_item                       r_in_item;
    logic                           r_out_valid;
    t_out_item                      r_out_item;
    logic [LEVELS-1:0][SLICE_W-1:0] r_slices;

    logic      in_acc;
    logic      step;
    t_out_item result;

    assign step             = r_in_valid && (!r_out_valid || o_sched_out.ready);
    assign i_sched_in.ready = i_rst_n && (!r_in_valid || step);
    assign in_acc           = i_sched_in.valid && i_sched_in.ready;
    assign i_cfg.ready      = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_sched_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_item.action  <= t_action'(i_sched_in.action);
            r_in_item.proc_id <= i_sched_in.proc_id;
            r_in_item.burst   <= i_sched_in.burst;
        end
        if (step) begin
            r_out_item <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LEVELS; k++) begin
                r_slices[k] <= SLICE_RST[k];
            end
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_SLICE_TOP: r_slices[0] <= i_cfg.wdata;
                CFG_SLICE_MID: r_slices[1] <= i_cfg.wdata;
                CFG_SLICE_LOW: r_slices[2] <= i_cfg.wdata;
                default: ;
            endcase
        end
    end

    mlfs_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PROC_COUNT  (PROC_COUNT)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .i_slices (r_slices),
        .o_result (result)
    );

    assign o_sched_out.valid     = r_out_valid;
    assign o_sched_out.run_valid = r_out_item.run_valid;
    assign o_sched_out.run_id    = r_out_item.run_id;
    assign o_sched_out.run_level = r_out_item.run_level;
    assign o_sched_out.finished  = r_out_item.finished;
    assign o_sched_out.dropped   = r_out_item.dropped;

endmodule

// File: rtl/mlfs_checker.sv
module mlfs_checker import mlfs_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_valid,
    input logic   i_in_ready,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input logic   i_run_valid,
    input t_id    i_run_id,
    input t_level i_run_level,
    input logic   i_finished,
    input logic   i_dropped
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable({i_run_valid, i_run_id, i_run_level, i_finished, i_dropped}))
        else $error("result beat changed while stalled");

    // a fresh result follows an input beat that passed the input and result registers
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result beat without a matching input beat");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_run_valid |-> i_run_id == '0 && i_run_level == '0 && !i_finished)
        else $error("idle result carries run fields");

    a_fin_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_finished |-> i_run_valid)
        else $error("finished without a running process");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid straight after reset");

endmodule

bind multilevel_feedback_scheduler mlfs_checker u_mlfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sched_in.valid),
    .i_in_ready  (i_sched_in.ready),
    .i_out_valid (o_sched_out.valid),
    .i_out_ready (o_sched_out.ready),
    .i_run_valid (o_sched_out.run_valid),
    .i_run_id    (o_sched_out.run_id),
    .i_run_level (o_sched_out.run_level),
    .i_finished  (o_sched_out.finished),
    .i_dropped   (o_sched_out.dropped)
);
